/* design/pma_pkg.sv */
package pma_pkg;

    localparam int ACTION_W = 2;
    localparam int PAGE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 21;
    localparam int COUNT_W  = 9;

    localparam logic [ACTION_W-1:0] ACT_TRANSLATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOCATE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE    = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    localparam int GRP_SIZE  = 16;
    localparam int GRP_IDX_W = 4;

endpackage

/* design/pma_slot_ram.sv */
module pma_slot_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [AW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [AW-1:0] rd_data
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] q_reg;
    logic          zero_reg;
    logic          w0_reg;

    // Entry zero reads as zero until it is first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w0_reg   <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_addr == '0))
            begin
                w0_reg <= 1'b1;
            end
            if (rd_en)
            begin
                zero_reg <= (rd_addr == '0) && !w0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = zero_reg ? '0 : q_reg;

endmodule

/* design/pma_scan.sv */
module pma_scan #(
    parameter int WIDTH = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [WIDTH-1:0]         used,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] idx
);
    import pma_pkg::*;

    localparam int NGRP  = (WIDTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_W = NGRP * GRP_SIZE;
    localparam int IW    = $clog2(WIDTH);

    logic [PAD_W-1:0]     padded;
    logic [NGRP-1:0]      grp_free_reg;
    logic [NGRP-1:0]      grp_free_next;
    logic [GRP_IDX_W-1:0] grp_idx_reg [NGRP];
    logic [GRP_IDX_W-1:0] grp_idx_next [NGRP];
    logic [11:0]          pos;

    always_comb
    begin
        padded = '1;
        padded[WIDTH-1:0] = used;
        for (int g = 0; g < NGRP; g++)
        begin
            grp_free_next[g] = 1'b0;
            grp_idx_next[g]  = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--)
            begin
                if (!padded[g * GRP_SIZE + b])
                begin
                    grp_free_next[g] = 1'b1;
                    grp_idx_next[g]  = GRP_IDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_free_reg <= '0;
        end
        else
        begin
            grp_free_reg <= grp_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_idx_reg[g] <= grp_idx_next[g];
        end
    end

    always_comb
    begin
        found = 1'b0;
        pos   = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                found = 1'b1;
                pos   = 12'(g * GRP_SIZE) + 12'(grp_idx_reg[g]);
            end
        end
        idx = pos[IW-1:0];
    end

endmodule

/* design/page_map_allocator_unit.sv */
// Channel   Direction  Handshake               Beat
// request   in         start high, busy low    action, page_id
// result    out        done strobe, one cycle  status, new_page, byte_offset
//
// A request is accepted in S_IDLE and executed in S_EXEC: the accept edge issues the
// slot memory read and samples the registered first level of the lowest-free search;
// the execute edge registers the result; no request is accepted while busy in S_EXEC.
// The result strobe is high in the cycle after the execute edge.
// Reset sets the maps in flip-flops at once, with only entry zero marked in use; no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
module page_map_allocator_unit #(
    parameter int MAX_PAGES  = 256,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pma_pkg::ACTION_W-1:0]   action,
    input  logic [pma_pkg::PAGE_W-1:0]     page_id,
    output logic                           done,
    output logic [pma_pkg::STATUS_W-1:0]   status,
    output logic [pma_pkg::PAGE_W-1:0]     new_page,
    output logic [pma_pkg::OFFSET_W-1:0]   byte_offset
);
    import pma_pkg::*;

    localparam int VIRT_SPACE = (MAX_PAGES < 256) ? MAX_PAGES : 256;
    localparam int VW         = $clog2(VIRT_SPACE);
    localparam logic [VIRT_SPACE-1:0] MAP_RESET = {{(VIRT_SPACE-1){1'b0}}, 1'b1};

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t                state_reg, state_next;
    logic [ACTION_W-1:0]   action_reg, action_next;
    logic                  hit_reg, hit_next;
    logic [VW-1:0]         id_reg, id_next;
    logic [VIRT_SPACE-1:0] virt_valid_reg, virt_valid_next;
    logic [VIRT_SPACE-1:0] phys_used_reg, phys_used_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [PAGE_W-1:0]     new_page_reg, new_page_next;
    logic [OFFSET_W-1:0]   offset_reg, offset_next;

    logic          accept;
    logic          in_space;
    logic          wr_en;
    logic [VW-1:0] slot_rd;
    logic          v_found, p_found;
    logic [VW-1:0] v_idx, p_idx;
    logic [8:0]    slot_plus;
    logic [25:0]   product;

    assign accept   = start && (state_reg == S_IDLE);
    assign in_space = {1'b0, page_id} < 9'(VIRT_SPACE);

    pma_slot_ram #(
        .DEPTH (VIRT_SPACE),
        .AW    (VW)
    ) u_slot_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (v_idx),
        .wr_data (p_idx),
        .rd_en   (accept),
        .rd_addr (page_id[VW-1:0]),
        .rd_data (slot_rd)
    );

    pma_scan #(
        .WIDTH (VIRT_SPACE)
    ) u_virt_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .used  (virt_valid_reg),
        .found (v_found),
        .idx   (v_idx)
    );

    pma_scan #(
        .WIDTH (VIRT_SPACE)
    ) u_phys_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .used  (phys_used_reg),
        .found (p_found),
        .idx   (p_idx)
    );

    assign slot_plus = 9'(slot_rd) + 9'd1;
    assign product   = 26'(slot_plus) * 26'(PAGE_BYTES);

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        hit_next        = hit_reg;
        id_next         = id_reg;
        virt_valid_next = virt_valid_reg;
        phys_used_next  = phys_used_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        new_page_next   = new_page_reg;
        offset_next     = offset_reg;
        wr_en           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next  = S_EXEC;
                    action_next = action;
                    id_next     = page_id[VW-1:0];
                    hit_next    = in_space && virt_valid_reg[page_id[VW-1:0]];
                end
            end
            S_EXEC:
            begin
                state_next    = S_IDLE;
                done_next     = 1'b1;
                status_next   = STATUS_OK;
                new_page_next = '0;
                offset_next   = '0;
                case (action_reg)
                    ACT_TRANSLATE:
                    begin
                        if (hit_reg)
                        begin
                            offset_next = product[OFFSET_W-1:0];
                        end
                        else
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                    ACT_ALLOCATE:
                    begin
                        if ((13'(count_reg) >= 13'(MAX_PAGES)) || !v_found || !p_found)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en                  = 1'b1;
                            virt_valid_next[v_idx] = 1'b1;
                            phys_used_next[p_idx]  = 1'b1;
                            count_next             = count_reg + 1'b1;
                            new_page_next          = PAGE_W'(v_idx);
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            virt_valid_next[id_reg] = 1'b0;
                            phys_used_next[slot_rd] = 1'b0;
                            count_next              = count_reg - 1'b1;
                        end
                        else
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            action_reg     <= ACT_TRANSLATE;
            hit_reg        <= 1'b0;
            id_reg         <= '0;
            virt_valid_reg <= MAP_RESET;
            phys_used_reg  <= MAP_RESET;
            count_reg      <= COUNT_W'(1);
            done_reg       <= 1'b0;
            status_reg     <= STATUS_OK;
            new_page_reg   <= '0;
            offset_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            action_reg     <= action_next;
            hit_reg        <= hit_next;
            id_reg         <= id_next;
            virt_valid_reg <= virt_valid_next;
            phys_used_reg  <= phys_used_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            new_page_reg   <= new_page_next;
            offset_reg     <= offset_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign new_page    = new_page_reg;
    assign byte_offset = offset_reg;

`ifndef SYNTHESIS
    a_virt_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(virt_valid_reg))
        else $error("mapped count does not match the virtual map");

    a_phys_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(phys_used_reg))
        else $error("mapped count does not match the physical map");

    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("result strobe missing after an accepted request");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");
`endif

endmodule

/* test/page_map_allocator_unit_tb.sv */
module page_map_allocator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pma_pkg::*;

    localparam int MAX_PAGES  = 256;
    localparam int PAGE_BYTES = 4096;
    localparam int VIRT_SPACE = (MAX_PAGES < 256) ? MAX_PAGES : 256;

    localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   new_page;
        logic [OFFSET_W-1:0] byte_offset;
    } page_result_t;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic [PAGE_W-1:0]   id;
        logic                typed;
        page_result_t        want;
    } directed_row_t;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } traffic_mode_t;

    localparam int DIRECTED_ROWS = 24;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 390;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [ACTION_W-1:0] action;
    logic [PAGE_W-1:0]   page_id;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   new_page;
    logic [OFFSET_W-1:0] byte_offset;

    bit                  virt_valid [256];
    logic [PAGE_W-1:0]   phys_slot [256];
    bit                  phys_used [MAX_PAGES];
    int                  mapped_count;

    page_result_t        pending_results [$];
    int                  error_count;
    bit                  idle_enable;

    directed_row_t directed_plan [DIRECTED_ROWS] = '{
        '{ACT_TRANSLATE, 8'd0,   1'b1, '{STATUS_OK,        8'd0, 21'd4096}},
        '{ACT_TRANSLATE, 8'd255, 1'b1, '{STATUS_NOT_FOUND, 8'd0, 21'd0}},
        '{ACT_REMOVE,    8'd255, 1'b1, '{STATUS_NOT_FOUND, 8'd0, 21'd0}},
        '{ACT_REMOVE,    8'd1,   1'b1, '{STATUS_NOT_FOUND, 8'd0, 21'd0}},
        '{ACT_UNDEFINED, 8'd255, 1'b1, '{STATUS_OK,        8'd0, 21'd0}},
        '{ACT_ALLOCATE,  8'hAA,  1'b1, '{STATUS_OK,        8'd1, 21'd0}},
        '{ACT_ALLOCATE,  8'd0,   1'b1, '{STATUS_OK,        8'd2, 21'd0}},
        '{ACT_TRANSLATE, 8'd1,   1'b1, '{STATUS_OK,        8'd0, 21'd8192}},
        '{ACT_TRANSLATE, 8'd2,   1'b1, '{STATUS_OK,        8'd0, 21'd12288}},
        '{ACT_REMOVE,    8'd0,   1'b1, '{STATUS_OK,        8'd0, 21'd0}},
        '{ACT_TRANSLATE, 8'd0,   1'b1, '{STATUS_NOT_FOUND, 8'd0, 21'd0}},
        '{ACT_REMOVE,    8'd0,   1'b1, '{STATUS_NOT_FOUND, 8'd0, 21'd0}},
        '{ACT_ALLOCATE,  8'hFF,  1'b1, '{STATUS_OK,        8'd0, 21'd0}},
        '{ACT_TRANSLATE, 8'd0,   1'b1, '{STATUS_OK,        8'd0, 21'd4096}},
        '{ACT_REMOVE,    8'd1,   1'b1, '{STATUS_OK,        8'd0, 21'd0}},
        '{ACT_REMOVE,    8'd2,   1'b1, '{STATUS_OK,        8'd0, 21'd0}},
        '{ACT_ALLOCATE,  8'h55,  1'b1, '{STATUS_OK,        8'd1, 21'd0}},
        '{ACT_TRANSLATE, 8'd1,   1'b1, '{STATUS_OK,        8'd0, 21'd8192}},
        '{ACT_UNDEFINED, 8'd0,   1'b1, '{STATUS_OK,        8'd0, 21'd0}},
        '{ACT_TRANSLATE, 8'd128, 1'b1, '{STATUS_NOT_FOUND, 8'd0, 21'd0}},
        '{ACT_TRANSLATE, 8'd127, 1'b0, '0},
        '{ACT_REMOVE,    8'd2,   1'b0, '0},
        '{ACT_ALLOCATE,  8'd0,   1'b0, '0},
        '{ACT_TRANSLATE, 8'd2,   1'b0, '0}
    };

    traffic_mode_t phase_plan [PHASES] = '{MODE_FILL, MODE_DRAIN, MODE_FILL, MODE_MIX, MODE_FILL};

    page_map_allocator_unit #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .page_id     (page_id),
        .done        (done),
        .status      (status),
        .new_page    (new_page),
        .byte_offset (byte_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("FAIL page_map_allocator_unit");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic clear_page_map();
        for (int i = 0; i < 256; i++)
        begin
            virt_valid[i] = 1'b0;
            phys_slot[i]  = '0;
        end
        for (int i = 0; i < MAX_PAGES; i++)
            phys_used[i] = 1'b0;
        virt_valid[0] = 1'b1;
        phys_used[0]  = 1'b1;
        mapped_count  = 1;
    endtask

    function automatic page_result_t apply_page_request(input logic [ACTION_W-1:0] act,
                                                        input logic [PAGE_W-1:0] id);
        page_result_t res;
        int           v;
        int           p;
        int           off;
        bit           in_space;
        res      = '{STATUS_OK, '0, '0};
        in_space = int'(id) < VIRT_SPACE;
        v        = -1;
        p        = -1;
        case (act)
            ACT_TRANSLATE:
            begin
                if (in_space && virt_valid[id])
                begin
                    off             = (int'(phys_slot[id]) + 1) * PAGE_BYTES;
                    res.byte_offset = off[OFFSET_W-1:0];
                end
                else
                    res.status = STATUS_NOT_FOUND;
            end
            ACT_ALLOCATE:
            begin
                if (mapped_count < MAX_PAGES)
                begin
                    for (int i = VIRT_SPACE - 1; i >= 0; i--)
                        if (!virt_valid[i])
                            v = i;
                    for (int i = MAX_PAGES - 1; i >= 0; i--)
                        if (!phys_used[i])
                            p = i;
                end
                if (v < 0 || p < 0)
                    res.status = STATUS_FULL;
                else
                begin
                    virt_valid[v] = 1'b1;
                    phys_slot[v]  = p[PAGE_W-1:0];
                    phys_used[p]  = 1'b1;
                    mapped_count++;
                    res.new_page  = v[PAGE_W-1:0];
                end
            end
            ACT_REMOVE:
            begin
                if (in_space && virt_valid[id])
                begin
                    virt_valid[id] = 1'b0;
                    if (int'(phys_slot[id]) < MAX_PAGES)
                        phys_used[phys_slot[id]] = 1'b0;
                    if (mapped_count > 0)
                        mapped_count--;
                end
                else
                    res.status = STATUS_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic logic [PAGE_W-1:0] pick_mapped_page();
        int base;
        int idx;
        base = $urandom_range(0, 255);
        for (int i = 0; i < 256; i++)
        begin
            idx = (base + i) % 256;
            if (virt_valid[idx])
                return idx[PAGE_W-1:0];
        end
        return base[PAGE_W-1:0];
    endfunction

    task automatic issue_request(input logic [ACTION_W-1:0] act, input logic [PAGE_W-1:0] id,
                                 input logic typed, input page_result_t want);
        int           gap;
        page_result_t predicted;
        gap = 0;
        if (idle_enable && $urandom_range(0, 99) < 36)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            start   <= 1'b0;
            action  <= ACTION_W'($urandom);
            page_id <= PAGE_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        action  <= act;
        page_id <= id;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = apply_page_request(act, id);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        page_result_t exp_beat;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with no request outstanding");
            else
            begin
                exp_beat = pending_results.pop_front();
                if (status !== exp_beat.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, exp_beat.status));
                if (new_page !== exp_beat.new_page)
                    report_mismatch($sformatf("new_page %0d, expected %0d",
                                              new_page, exp_beat.new_page));
                if (byte_offset !== exp_beat.byte_offset)
                    report_mismatch($sformatf("byte_offset %0d, expected %0d",
                                              byte_offset, exp_beat.byte_offset));
            end
        end
    end

    initial
    begin
        logic [ACTION_W-1:0] act;
        logic [PAGE_W-1:0]   id;
        int                  r;
        int                  item;
        int                  waited;
        error_count = 0;
        idle_enable = 1'b1;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        action  <= '0;
        page_id <= '0;
        clear_page_map();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_request(directed_plan[i].act, directed_plan[i].id,
                          directed_plan[i].typed, directed_plan[i].want);

        item = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                idle_enable = !(item >= 900 && item < 1250);
                r = $urandom_range(0, 99);
                case (phase_plan[ph])
                    MODE_FILL:
                        act = (r < 85) ? ACT_ALLOCATE : (r < 95) ? ACT_TRANSLATE :
                              (r < 98) ? ACT_REMOVE : ACT_UNDEFINED;
                    MODE_DRAIN:
                        act = (r < 80) ? ACT_REMOVE : (r < 90) ? ACT_TRANSLATE :
                              (r < 97) ? ACT_ALLOCATE : ACT_UNDEFINED;
                    default:
                        act = (r < 35) ? ACT_ALLOCATE : (r < 65) ? ACT_TRANSLATE :
                              (r < 95) ? ACT_REMOVE : ACT_UNDEFINED;
                endcase
                if ((act == ACT_TRANSLATE || act == ACT_REMOVE) && $urandom_range(0, 99) < 70)
                    id = pick_mapped_page();
                else
                    id = PAGE_W'($urandom_range(0, 255));
                issue_request(act, id, 1'b0, '0);
                item++;
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("PASS page_map_allocator_unit");
        else
            $display("FAIL page_map_allocator_unit");
        $finish;
    end

endmodule

/* files.f */
design/pma_pkg.sv
design/pma_slot_ram.sv
design/pma_scan.sv
design/page_map_allocator_unit.sv
test/page_map_allocator_unit_tb.sv
